@@ design/hhc_pkg.sv @@
`timescale 1ns / 1ps
package hhc_pkg;
	localparam int PosW = 24;
	localparam int VelW = 16;
	localparam int DistW = 25;
	localparam int SpdW = 16;
	localparam int StampW = 63;
	localparam int DwellW = 48;
	localparam int FlagW = 5;
	localparam int SumW = 52;
	localparam int RootW = 26;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 48;

	localparam logic [CfgIdxW-1:0] REG_GOAL_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_GOAL_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GOAL_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GOAL_TOL = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HOLD_TOL = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SPEED_LIM = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_DWELL = 3'd6;

	localparam int FLAG_ARMED = 0;
	localparam int FLAG_AIR = 1;
	localparam int FLAG_POS = 2;
	localparam int FLAG_VEL = 3;
	localparam int FLAG_HOLD = 4;

	typedef struct packed {
		logic [StampW-1:0] stamp;
		logic [FlagW-1:0] status_flags;
		logic signed [PosW-1:0] position_x;
		logic signed [PosW-1:0] position_y;
		logic signed [PosW-1:0] position_z;
		logic signed [VelW-1:0] velocity_x;
		logic signed [VelW-1:0] velocity_y;
		logic signed [VelW-1:0] velocity_z;
		logic signed [PosW-1:0] hold_x;
		logic signed [PosW-1:0] hold_y;
		logic signed [PosW-1:0] hold_z;
	} in_word_t;

	typedef struct packed {
		logic [DistW-1:0] goal_distance;
		logic [DistW-1:0] hold_error;
		logic [SpdW-1:0] speed_value;
		logic confirmed;
		logic first_confirm;
	} out_word_t;

	// datapath operation select
	typedef enum logic [1:0] {
		OP_GOAL = 2'd0,
		OP_HOLD = 2'd1,
		OP_SPEED = 2'd2
	} op_t;

	typedef struct packed {
		logic load;
		logic sq_start;
		logic [1:0] term;
		logic acc_clear;
		logic acc_add;
		logic rt_start;
		logic rt_step;
		op_t op;
		logic store;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic rt_done;
	} stat_t;
endpackage

@@ design/hhc_if.sv @@
`timescale 1ns / 1ps
interface hhc_in_if;
	logic valid;
	logic ready;
	hhc_pkg::in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hhc_out_if;
	logic valid;
	logic ready;
	hhc_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/hhc_ctrl.sv @@
`timescale 1ns / 1ps
module hhc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output hhc_pkg::cmd_t cmd,
	input hhc_pkg::stat_t stat
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SQ = 7'b0000010,
		S_ACC = 7'b0000100,
		S_ROOT = 7'b0001000,
		S_STORE = 7'b0010000,
		S_DEC = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0] term_q;
	hhc_pkg::op_t op_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.term = term_q;
		cmd.op = op_q;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_SQ: cmd.sq_start = 1'b1;
			S_ACC: cmd.acc_add = 1'b1;
			S_ROOT: cmd.rt_step = 1'b1;
			S_STORE: cmd.store = 1'b1;
			S_DEC: cmd.decide = 1'b1;
			S_OUT: ;
			default: ;
		endcase
		if (state_q == S_IDLE || state_q == S_STORE) cmd.acc_clear = 1'b1;
		if (state_q == S_ACC && term_q == 2'd2) cmd.rt_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q <= '0;
			op_q <= hhc_pkg::OP_GOAL;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_SQ;
					term_q <= '0;
					op_q <= hhc_pkg::OP_GOAL;
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: if (term_q == 2'd2) state_q <= S_ROOT;
					else begin
						term_q <= term_q + 2'd1;
						state_q <= S_SQ;
					end
				S_ROOT: if (stat.rt_done) state_q <= S_STORE;
				S_STORE: begin
					term_q <= '0;
					unique case (op_q)
						hhc_pkg::OP_GOAL: begin
							op_q <= hhc_pkg::OP_HOLD;
							state_q <= S_SQ;
						end
						hhc_pkg::OP_HOLD: begin
							op_q <= hhc_pkg::OP_SPEED;
							state_q <= S_SQ;
						end
						default: state_q <= S_DEC;
					endcase
				end
				S_DEC: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/hhc_dp.sv @@
`timescale 1ns / 1ps
module hhc_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hhc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [hhc_pkg::CfgDataW-1:0] cfg_data,
	input hhc_pkg::in_word_t in_data,
	input hhc_pkg::cmd_t cmd,
	output hhc_pkg::stat_t stat,
	output hhc_pkg::out_word_t out_data
);
	localparam int DW = hhc_pkg::PosW + 1;
	localparam int SqW = 2 * DW;

	logic signed [hhc_pkg::PosW-1:0] goal_x_q, goal_y_q, goal_z_q;
	logic [hhc_pkg::DistW-1:0] goal_tol_q, hold_tol_q;
	logic [hhc_pkg::SpdW-1:0] speed_lim_q;
	logic [hhc_pkg::DwellW-1:0] dwell_q;

	hhc_pkg::in_word_t in_q;
	logic confirmed_q, running_q, newly_q;
	logic [hhc_pkg::StampW-1:0] start_q;

	logic [SqW-1:0] sq_q;
	logic [hhc_pkg::SumW-1:0] acc_q;
	logic [hhc_pkg::SumW-1:0] rem_q;
	logic [hhc_pkg::RootW-1:0] root_q;
	logic [4:0] cnt_q;
	logic [hhc_pkg::DistW-1:0] gd_q, he_q;
	logic [hhc_pkg::SpdW-1:0] sp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
			goal_z_q <= '0;
			goal_tol_q <= hhc_pkg::DistW'(500);
			hold_tol_q <= hhc_pkg::DistW'(300);
			speed_lim_q <= hhc_pkg::SpdW'(200);
			dwell_q <= hhc_pkg::DwellW'(2000000000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				hhc_pkg::REG_GOAL_X: goal_x_q <= cfg_data[hhc_pkg::PosW-1:0];
				hhc_pkg::REG_GOAL_Y: goal_y_q <= cfg_data[hhc_pkg::PosW-1:0];
				hhc_pkg::REG_GOAL_Z: goal_z_q <= cfg_data[hhc_pkg::PosW-1:0];
				hhc_pkg::REG_GOAL_TOL: goal_tol_q <= cfg_data[hhc_pkg::DistW-1:0];
				hhc_pkg::REG_HOLD_TOL: hold_tol_q <= cfg_data[hhc_pkg::DistW-1:0];
				hhc_pkg::REG_SPEED_LIM: speed_lim_q <= cfg_data[hhc_pkg::SpdW-1:0];
				hhc_pkg::REG_DWELL: dwell_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) if (cmd.load) in_q <= in_data;

	// operand select for one squared term
	logic signed [DW-1:0] a, b, d;
	logic [DW-1:0] m;
	always_comb begin
		a = '0;
		b = '0;
		unique case (cmd.op)
			hhc_pkg::OP_SPEED: begin
				unique case (cmd.term)
					2'd0: a = DW'(in_q.velocity_x);
					2'd1: a = DW'(in_q.velocity_y);
					default: a = DW'(in_q.velocity_z);
				endcase
			end
			default: begin
				unique case (cmd.term)
					2'd0: a = DW'(in_q.position_x);
					2'd1: a = DW'(in_q.position_y);
					default: a = DW'(in_q.position_z);
				endcase
				if (cmd.op == hhc_pkg::OP_GOAL) begin
					unique case (cmd.term)
						2'd0: b = DW'(goal_x_q);
						2'd1: b = DW'(goal_y_q);
						default: b = DW'(goal_z_q);
					endcase
				end else begin
					unique case (cmd.term)
						2'd0: b = DW'(in_q.hold_x);
						2'd1: b = DW'(in_q.hold_y);
						default: b = DW'(in_q.hold_z);
					endcase
				end
			end
		endcase
		d = a - b;
		m = d[DW-1] ? DW'(-d) : DW'(d);
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_start) sq_q <= m * m;
		if (cmd.acc_clear) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + hhc_pkg::SumW'(sq_q);
	end

	// radix-4 restoring square root, one result bit a cycle
	logic [hhc_pkg::SumW-1:0] trial, rem_sh;
	logic [hhc_pkg::RootW-1:0] root_sh;
	always_comb begin
		rem_sh = {rem_q[hhc_pkg::SumW-3:0], 2'b00};
		root_sh = {root_q[hhc_pkg::RootW-2:0], 1'b0};
		trial = hhc_pkg::SumW'({root_sh, 1'b1});
	end

	logic [hhc_pkg::SumW-1:0] src_q;
	logic [hhc_pkg::SumW-1:0] part;
	assign part = {rem_q[hhc_pkg::SumW-3:0], src_q[hhc_pkg::SumW-1 -: 2]};

	always_ff @(posedge clk) begin
		if (cmd.rt_start) begin
			src_q <= acc_q + hhc_pkg::SumW'(sq_q);
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= '0;
		end else if (cmd.rt_step && cnt_q != 5'(hhc_pkg::RootW)) begin
			src_q <= {src_q[hhc_pkg::SumW-3:0], 2'b00};
			cnt_q <= cnt_q + 5'd1;
			if (part >= trial) begin
				rem_q <= part - trial;
				root_q <= {root_q[hhc_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q <= part;
				root_q <= root_sh;
			end
		end
	end
	assign stat.rt_done = (cnt_q == 5'(hhc_pkg::RootW)) && !cmd.rt_start;

	logic pos_ok, vel_ok, hold_ok;
	assign pos_ok = in_q.status_flags[hhc_pkg::FLAG_POS];
	assign vel_ok = in_q.status_flags[hhc_pkg::FLAG_VEL];
	assign hold_ok = in_q.status_flags[hhc_pkg::FLAG_HOLD];

	always_ff @(posedge clk) if (cmd.store) begin
		unique case (cmd.op)
			hhc_pkg::OP_GOAL: gd_q <= pos_ok ? root_q[hhc_pkg::DistW-1:0] : '1;
			hhc_pkg::OP_HOLD: he_q <= (pos_ok && hold_ok) ? root_q[hhc_pkg::DistW-1:0] : '1;
			default: sp_q <= vel_ok ? root_q[hhc_pkg::SpdW-1:0] : '1;
		endcase
	end

	logic stable;
	logic [hhc_pkg::StampW-1:0] elapsed;
	assign stable = (in_q.stamp != '0) && in_q.status_flags[hhc_pkg::FLAG_ARMED]
		&& in_q.status_flags[hhc_pkg::FLAG_AIR] && hold_ok && pos_ok && vel_ok
		&& (gd_q <= goal_tol_q) && (he_q <= hold_tol_q) && (sp_q <= speed_lim_q);
	assign elapsed = in_q.stamp - start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirmed_q <= 1'b0;
			running_q <= 1'b0;
			start_q <= '0;
			newly_q <= 1'b0;
		end else if (cmd.decide) begin
			newly_q <= 1'b0;
			if (!confirmed_q) begin
				if (!stable) running_q <= 1'b0;
				else if (!running_q || in_q.stamp < start_q) begin
					running_q <= 1'b1;
					start_q <= in_q.stamp;
				end else if (elapsed >= hhc_pkg::StampW'(dwell_q)) begin
					confirmed_q <= 1'b1;
					newly_q <= 1'b1;
				end
			end
		end
	end

	assign out_data.goal_distance = gd_q;
	assign out_data.hold_error = he_q;
	assign out_data.speed_value = sp_q;
	assign out_data.confirmed = confirmed_q;
	assign out_data.first_confirm = newly_q;
endmodule

@@ design/hover_hold_confirmation_top.sv @@
`timescale 1ns / 1ps
// channel  dir  payload
// in_ch    in   in_word_t sample
// out_ch   out  out_word_t result
// cfg      in   cfg_we / cfg_index / cfg_data
// each word runs the shared squarer and the one-bit-a-cycle square root once for
// each of three values: goal distance, hold error and speed
// the result is held in registers until taken; no new word is taken meanwhile
// arst_n clears control and loads register defaults
module hover_hold_confirmation_top (
	input logic clk,
	input logic arst_n,
	hhc_in_if.sink in_ch,
	hhc_out_if.source out_ch,
	input logic cfg_we,
	input logic [hhc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [hhc_pkg::CfgDataW-1:0] cfg_data
);
	hhc_pkg::cmd_t cmd;
	hhc_pkg::stat_t stat;

	hhc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .stat(stat)
	);

	hhc_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_data(in_ch.data), .cmd(cmd), .stat(stat), .out_data(out_ch.data)
	);
endmodule

@@ design/hhc_checker.sv @@
`timescale 1ns / 1ps
module hhc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic confirmed,
	input logic newly
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out dropped");
	a_newly_conf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && newly |-> confirmed) else $error("newly without confirmed");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind hover_hold_confirmation_top hhc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.confirmed(out_ch.data.confirmed), .newly(out_ch.data.first_confirm)
);

@@ sim/tb_hover_hold_confirmation_top.sv @@
`timescale 1ns / 1ps
module tb_hover_hold_confirmation_top;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [hhc_pkg::CfgIdxW-1:0] cfg_index;
	logic [hhc_pkg::CfgDataW-1:0] cfg_data;

	hhc_in_if in_ch();
	hhc_out_if out_ch();

	hover_hold_confirmation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of registers and dwell state
	logic signed [hhc_pkg::PosW-1:0] goal_x_r, goal_y_r, goal_z_r;
	logic [hhc_pkg::DistW-1:0] goal_tol_r, hold_tol_r;
	logic [hhc_pkg::SpdW-1:0] speed_lim_r;
	logic [hhc_pkg::DwellW-1:0] dwell_r;
	logic hold_confirmed;
	logic dwell_active;
	logic [hhc_pkg::StampW-1:0] dwell_origin;

	hhc_pkg::in_word_t sample_queue[$];
	hhc_pkg::out_word_t expected_words[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int words_checked;
	int confirm_count;
	longint cycle_count;
	logic stamp_walk_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] span_sq(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic hhc_pkg::out_word_t predict_hold(input hhc_pkg::in_word_t s);
		hhc_pkg::out_word_t r;
		logic pos_ok, vel_ok, hold_ok, stable;
		logic [63:0] gd, he, sp;
		pos_ok = s.status_flags[hhc_pkg::FLAG_POS];
		vel_ok = s.status_flags[hhc_pkg::FLAG_VEL];
		hold_ok = s.status_flags[hhc_pkg::FLAG_HOLD];
		gd = {64{1'b1}};
		he = {64{1'b1}};
		sp = {64{1'b1}};
		if (pos_ok)
			gd = floor_root(span_sq(s.position_x, goal_x_r) + span_sq(s.position_y, goal_y_r)
				+ span_sq(s.position_z, goal_z_r));
		if (pos_ok && hold_ok)
			he = floor_root(span_sq(s.position_x, s.hold_x) + span_sq(s.position_y, s.hold_y)
				+ span_sq(s.position_z, s.hold_z));
		if (vel_ok)
			sp = floor_root(span_sq(s.velocity_x, 0) + span_sq(s.velocity_y, 0)
				+ span_sq(s.velocity_z, 0));
		r.first_confirm = 1'b0;
		if (!hold_confirmed) begin
			stable = s.stamp != 0 && s.status_flags[hhc_pkg::FLAG_ARMED]
				&& s.status_flags[hhc_pkg::FLAG_AIR]
				&& hold_ok && pos_ok && vel_ok && gd <= goal_tol_r && he <= hold_tol_r
				&& sp <= speed_lim_r;
			if (!stable) begin
				dwell_active = 1'b0;
			end else if (!dwell_active || s.stamp < dwell_origin) begin
				dwell_active = 1'b1;
				dwell_origin = s.stamp;
			end else if (s.stamp - dwell_origin >= {15'd0, dwell_r}) begin
				hold_confirmed = 1'b1;
				r.first_confirm = 1'b1;
			end
		end
		r.goal_distance = gd[hhc_pkg::DistW-1:0];
		r.hold_error = he[hhc_pkg::DistW-1:0];
		r.speed_value = sp[hhc_pkg::SpdW-1:0];
		r.confirmed = hold_confirmed;
		return r;
	endfunction

	task automatic write_reg(input logic [hhc_pkg::CfgIdxW-1:0] idx,
			input logic [hhc_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hhc_pkg::REG_GOAL_X: goal_x_r = val[hhc_pkg::PosW-1:0];
			hhc_pkg::REG_GOAL_Y: goal_y_r = val[hhc_pkg::PosW-1:0];
			hhc_pkg::REG_GOAL_Z: goal_z_r = val[hhc_pkg::PosW-1:0];
			hhc_pkg::REG_GOAL_TOL: goal_tol_r = val[hhc_pkg::DistW-1:0];
			hhc_pkg::REG_HOLD_TOL: hold_tol_r = val[hhc_pkg::DistW-1:0];
			hhc_pkg::REG_SPEED_LIM: speed_lim_r = val[hhc_pkg::SpdW-1:0];
			hhc_pkg::REG_DWELL: dwell_r = val[hhc_pkg::DwellW-1:0];
			default: ;
		endcase
	endtask

	task automatic drain_all();
		while (sample_queue.size() != 0 || expected_words.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic signed [hhc_pkg::PosW-1:0] near_pos(
			input logic signed [hhc_pkg::PosW-1:0] c, input int spread);
		longint v;
		v = longint'(c) + $signed($urandom_range(2 * spread)) - spread;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[hhc_pkg::PosW-1:0];
	endfunction

	function automatic hhc_pkg::in_word_t random_sample(input logic [hhc_pkg::StampW-1:0] stamp,
			input int mode);
		hhc_pkg::in_word_t s;
		s = ($bits(hhc_pkg::in_word_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		s.stamp = stamp;
		if (mode != 0) begin
			// mostly well-formed hovering samples close to goal and hold
			s.status_flags = ($urandom_range(9) == 0) ? 5'($urandom) : 5'b11111;
			s.position_x = near_pos(goal_x_r, 300);
			s.position_y = near_pos(goal_y_r, 300);
			s.position_z = near_pos(goal_z_r, 300);
			s.hold_x = near_pos(s.position_x, 200);
			s.hold_y = near_pos(s.position_y, 200);
			s.hold_z = near_pos(s.position_z, 200);
			s.velocity_x = 16'($signed($urandom_range(300)) - 150);
			s.velocity_y = 16'($signed($urandom_range(300)) - 150);
			s.velocity_z = 16'($signed($urandom_range(300)) - 150);
		end
		return s;
	endfunction

	task automatic run_random(input int count, input logic [hhc_pkg::StampW-1:0] stamp_base);
		logic [hhc_pkg::StampW-1:0] t;
		int k;
		t = stamp_base;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(19))
				0: t = t - hhc_pkg::StampW'($urandom_range(1000));
				1: t = hhc_pkg::StampW'({$urandom, $urandom});
				default: t = t + hhc_pkg::StampW'($urandom_range(
					(dwell_r[47:32] == 16'd0 ? dwell_r[31:0] : 32'hffffffff) / 32'd3 + 32'd1));
			endcase
			sample_queue.insert(sample_queue.size(), random_sample(t, $urandom_range(7) != 0));
		end
	endtask

	initial begin
		hhc_pkg::in_word_t s;
		int ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hhc_pkg::REG_GOAL_X;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		words_checked = 0;
		confirm_count = 0;
		stamp_walk_done = 1'b0;
		goal_x_r = 0; goal_y_r = 0; goal_z_r = 0;
		goal_tol_r = 500; hold_tol_r = 300; speed_lim_r = 200;
		dwell_r = 48'd2000000000;
		hold_confirmed = 1'b0;
		dwell_active = 1'b0;
		dwell_origin = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: defaults, extremes, unavailable codes, backwards time, confirm
		s = '0;
		s.status_flags = 5'b11111;
		sample_queue.insert(sample_queue.size(), s);
		s.stamp = 63'd100;
		sample_queue.insert(sample_queue.size(), s);
		s.stamp = {hhc_pkg::StampW{1'b1}};
		s.position_x = 24'sh7fffff; s.position_y = 24'sh800000; s.position_z = 24'sh7fffff;
		s.hold_x = 24'sh800000; s.hold_y = 24'sh7fffff; s.hold_z = 24'sh800000;
		s.velocity_x = 16'sh8000; s.velocity_y = 16'sh8000; s.velocity_z = 16'sh8000;
		sample_queue.insert(sample_queue.size(), s);
		s.status_flags = 5'b00000;
		sample_queue.insert(sample_queue.size(), s);
		s = '0;
		for (ph = 0; ph < 5; ph++) begin
			s.stamp = 63'd1000;
			s.status_flags = 5'b11111 ^ (5'd1 << ph);
			sample_queue.insert(sample_queue.size(), s);
		end
		s.status_flags = 5'b11111;
		s.stamp = 63'd5000;
		sample_queue.insert(sample_queue.size(), s);
		s.stamp = 63'd4000;
		sample_queue.insert(sample_queue.size(), s);
		s.stamp = 63'd2000004000;
		sample_queue.insert(sample_queue.size(), s);
		s.stamp = 63'd5;
		sample_queue.insert(sample_queue.size(), s);
		drain_all();

		// zero dwell, zero tolerances, extreme goal
		write_reg(hhc_pkg::REG_DWELL, 48'd0);
		write_reg(hhc_pkg::REG_GOAL_TOL, 48'd0);
		write_reg(hhc_pkg::REG_HOLD_TOL, 48'd0);
		write_reg(hhc_pkg::REG_SPEED_LIM, 48'd0);
		write_reg(hhc_pkg::REG_GOAL_X, 48'h800000);
		write_reg(hhc_pkg::REG_GOAL_Y, 48'h7fffff);
		write_reg(hhc_pkg::REG_GOAL_Z, 48'h800000);
		hold_confirmed = hold_confirmed;
		s = '0;
		s.status_flags = 5'b11111;
		s.position_x = 24'sh800000; s.position_y = 24'sh7fffff; s.position_z = 24'sh800000;
		s.hold_x = s.position_x; s.hold_y = s.position_y; s.hold_z = s.position_z;
		s.stamp = 63'd7;
		sample_queue.insert(sample_queue.size(), s);
		sample_queue.insert(sample_queue.size(), s);
		drain_all();

		// random phases over several settings and idling profiles
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 79; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 79; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			write_reg(hhc_pkg::REG_GOAL_X, 48'($signed($urandom_range(20000)) - 10000));
			write_reg(hhc_pkg::REG_GOAL_Y, 48'($urandom));
			write_reg(hhc_pkg::REG_GOAL_Z, 48'($signed($urandom_range(20000)) - 10000));
			write_reg(hhc_pkg::REG_GOAL_TOL,
				ph == 3 ? 48'd33554430 : 48'($urandom_range(100, 600)));
			write_reg(hhc_pkg::REG_HOLD_TOL, ph == 2 ? 48'd1 : 48'($urandom_range(100, 400)));
			write_reg(hhc_pkg::REG_SPEED_LIM,
				ph == 1 ? 48'd65534 : 48'($urandom_range(100, 300)));
			write_reg(hhc_pkg::REG_DWELL,
				ph == 3 ? 48'hffffffffffff : 48'($urandom_range(20000)));
			run_random(200, 63'($urandom_range(1000)));
			drain_all();
			// each phase rewrites every register, but no phase can confirm afresh;
			// confirmation stays latched until reset
		end
		stamp_walk_done = 1'b1;
	end

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_ch.ready) begin
				if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= sample_queue[0];
					expected_words.insert(expected_words.size(),
						predict_hold(sample_queue.pop_front()));
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t unexpected word %h", $time, out_ch.data);
					mismatches <= mismatches + 1;
				end else begin
					if (out_ch.data !== expected_words[0]) begin
						$display("%0t mismatch expected %h actual %h", $time, expected_words[0],
							out_ch.data);
						mismatches <= mismatches + 1;
					end
					if (out_ch.data.first_confirm) confirm_count <= confirm_count + 1;
					void'(expected_words.pop_front());
					words_checked <= words_checked + 1;
				end
			end
		end
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		if (stamp_walk_done) begin
			$display("checked %0d result words, %0d confirmations, four idling profiles",
				words_checked, confirm_count);
			if (mismatches == 0 && expected_words.size() == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
			$finish;
		end else if (cycle_count > 2000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end
endmodule

@@ files.f @@
design/hhc_pkg.sv
design/hhc_if.sv
design/hhc_ctrl.sv
design/hhc_dp.sv
design/hover_hold_confirmation_top.sv
design/hhc_checker.sv
sim/tb_hover_hold_confirmation_top.sv
